/* hdl/sas_pkg.sv */
package sas_pkg;

  localparam int unsigned ID_BITS  = 15;
  localparam int unsigned LEN_BITS = 11;
  localparam int unsigned WORD_BITS = 16;

  // ids at or beyond next by less than ((1 << ID_BITS) - 1) / 2, one under half the id space, count as ahead
  localparam logic [ID_BITS-1:0] AHEAD_LIM = ID_BITS'(((1 << ID_BITS) - 1) / 2);

  localparam logic [WORD_BITS-1:0] OPEN_SESSION = {8'h13, 8'h37};

  typedef enum logic [1:0] {
    ACT_RX    = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OP_OTHER   = 3'd0,
    OP_ACCEPT  = 3'd1,
    OP_REJECT  = 3'd2,
    OP_CLOSING = 3'd3,
    OP_CLOSED  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_REPLY    = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_CLOSING  = 3'd4,
    ST_CLOSED   = 3'd5,
    ST_REJECTED = 3'd6,
    ST_BAD_OP   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    RK_NONE  = 3'd0,
    RK_OPEN  = 3'd1,
    RK_ACK   = 3'd2,
    RK_CLOSE = 3'd3,
    RK_RETX  = 3'd4
  } reply_e;

  typedef struct packed {
    logic [1:0]           action;
    logic                 flag_syn;
    logic                 flag_ackreq;
    logic [2:0]           opcode_kind;
    logic [WORD_BITS-1:0] session_id;
    logic [WORD_BITS-1:0] remote_id;
    logic [WORD_BITS-1:0] packet_len;
  } sas_req_t;

  typedef struct packed {
    status_e              status;
    reply_e               reply_kind;
    logic                 reply_retx;
    logic                 reply_close_op;
    logic [WORD_BITS-1:0] reply_session;
    logic [WORD_BITS-1:0] reply_id;
    logic [LEN_BITS-1:0]  payload_len;
  } sas_res_t;

  typedef struct packed {
    reply_e               armed;
    logic [ID_BITS-1:0]   last_acked_id;
    logic [WORD_BITS-1:0] ack_session;
    logic [WORD_BITS-1:0] ack_id_word;
    logic [WORD_BITS-1:0] close_session;
    logic                 close_retx;
    logic                 close_is_closed;
    logic [WORD_BITS-1:0] retx_session;
    logic [ID_BITS-1:0]   retx_wanted_id;
    logic                 open_retx;
    logic [WORD_BITS-1:0] last_rx_session;
    logic [LEN_BITS-1:0]  held_len;
  } sas_state_t;

endpackage

/* hdl/sas_intf.sv */
interface sas_in_if import sas_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic                 flag_syn;
  logic                 flag_ackreq;
  logic [2:0]           opcode_kind;
  logic [WORD_BITS-1:0] session_id;
  logic [WORD_BITS-1:0] remote_id;
  logic [WORD_BITS-1:0] packet_len;

  modport source (
    output valid, action, flag_syn, flag_ackreq, opcode_kind, session_id, remote_id,
           packet_len,
    input  ready
  );
  modport sink (
    input  valid, action, flag_syn, flag_ackreq, opcode_kind, session_id, remote_id,
           packet_len,
    output ready
  );
endinterface

interface sas_out_if import sas_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [2:0]           reply_kind;
  logic                 reply_retx;
  logic                 reply_close_op;
  logic [WORD_BITS-1:0] reply_session;
  logic [WORD_BITS-1:0] reply_id;
  logic [LEN_BITS-1:0]  payload_len;

  modport source (
    output valid, status, reply_kind, reply_retx, reply_close_op, reply_session, reply_id,
           payload_len,
    input  ready
  );
  modport sink (
    input  valid, status, reply_kind, reply_retx, reply_close_op, reply_session, reply_id,
           payload_len,
    output ready
  );
endinterface

/* hdl/session_ack_sequencer_core.sv */
// channel  dir  modport          carries
// in_i     in   sas_in_if.sink   one request: received header, host open or host close
// out_o    out  sas_out_if.source one result: status and the armed reply
//
// two register stages: the request register, then the session logic feeding
// the result register; one request per cycle sustained while out_o.ready stays high
// the session state updates in the same cycle a request leaves the request register
// rst_ni clears the session state (no reply armed) and both valid flags
// out_o.ready low holds the result; an empty request register still takes one
// more request, then in_i.ready drops until the result is taken
module session_ack_sequencer_core import sas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sas_in_if.sink    in_i,
  sas_out_if.source out_o
);

  sas_req_t in_req, s1_req;
  logic     s1_valid;
  sas_res_t res_d, res_q;
  logic     out_valid_q, out_valid_d;
  logic     s2_ready, fire;

  // pack the incoming request fields
  assign in_req.action      = in_i.action;
  assign in_req.flag_syn    = in_i.flag_syn;
  assign in_req.flag_ackreq = in_i.flag_ackreq;
  assign in_req.opcode_kind = in_i.opcode_kind;
  assign in_req.session_id  = in_i.session_id;
  assign in_req.remote_id   = in_i.remote_id;
  assign in_req.packet_len  = in_i.packet_len;

  // result register is free when empty or being drained this cycle
  assign s2_ready = !out_valid_q || out_o.ready;
  assign fire     = s1_valid && s2_ready;

  sas_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_i.ready),
    .req_i      (in_req),
    .ds_ready_i (s2_ready),
    .valid_o    (s1_valid),
    .req_o      (s1_req)
  );

  // session logic and state, committed only when the request moves on
  sas_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (s1_req),
    .res_o  (res_d)
  );

  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = res_q.status;
  assign out_o.reply_kind     = res_q.reply_kind;
  assign out_o.reply_retx     = res_q.reply_retx;
  assign out_o.reply_close_op = res_q.reply_close_op;
  assign out_o.reply_session  = res_q.reply_session;
  assign out_o.reply_id       = res_q.reply_id;
  assign out_o.payload_len    = res_q.payload_len;

`ifndef SYNTHESIS
  // a request leaving the request register always lands in the result register
  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("request lost between stages");

  // an in-order payload always arms an ack
  a_payload_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_PAYLOAD) |-> (res_q.reply_kind == RK_ACK))
    else $error("payload status without armed ack");

  // open reply carries the fixed session word and no id
  a_open_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.reply_kind == RK_OPEN)
      |-> (res_q.reply_session == OPEN_SESSION && res_q.reply_id == '0))
    else $error("open reply fields wrong");

  // result register holds while the sink stalls
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(res_q)))
    else $error("result changed under stall");
`endif

endmodule

/* hdl/sas_in_reg.sv */
module sas_in_reg import sas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  sas_req_t req_i,
  input  logic     ds_ready_i,
  output logic     valid_o,
  output sas_req_t req_o
);

  logic     valid_q, valid_d;
  sas_req_t req_q;
  logic     load;

  assign ready_o = !valid_q || ds_ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ds_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

/* hdl/sas_engine.sv */
module sas_engine import sas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  sas_req_t req_i,
  output sas_res_t res_o
);

  sas_state_t         st_q, st_d;
  status_e            status;
  logic [ID_BITS-1:0] next_id, got_id, id_diff;

  assign next_id = st_q.last_acked_id + ID_BITS'(1);
  assign got_id  = req_i.remote_id[ID_BITS-1:0];
  assign id_diff = got_id - next_id;

  always_comb begin
    st_d   = st_q;
    status = ST_NONE;
    case (req_i.action)
      ACT_RX: begin
        st_d.last_rx_session = req_i.session_id;
        if (st_q.armed == RK_CLOSE) begin
          st_d.close_retx      = 1'b1;
          st_d.close_is_closed = 1'b0;
          if (req_i.flag_syn && req_i.opcode_kind == OP_CLOSED) begin
            status = ST_CLOSED;
          end else begin
            if (req_i.flag_syn && req_i.opcode_kind == OP_CLOSING) begin
              st_d.close_retx      = 1'b0;
              st_d.close_is_closed = 1'b1;
            end
            st_d.close_session = req_i.session_id;
            status             = ST_REPLY;
          end
        end else if (req_i.flag_ackreq) begin
          if (got_id == next_id) begin
            st_d.last_acked_id = got_id;
            st_d.armed         = RK_ACK;
            st_d.ack_session   = req_i.session_id;
            st_d.ack_id_word   = req_i.remote_id;
            st_d.held_len      = req_i.packet_len[LEN_BITS-1:0];
            status             = ST_PAYLOAD;
          end else begin
            if (id_diff < AHEAD_LIM) begin
              st_d.armed          = RK_RETX;
              st_d.retx_session   = req_i.session_id;
              st_d.retx_wanted_id = next_id;
            end else begin
              st_d.armed       = RK_ACK;
              st_d.ack_session = req_i.session_id;
              st_d.ack_id_word = WORD_BITS'(st_q.last_acked_id);
            end
            status = ST_REPLY;
          end
        end else if (req_i.flag_syn) begin
          case (req_i.opcode_kind)
            OP_ACCEPT: begin
              st_d.ack_session = req_i.session_id;
              st_d.ack_id_word = '0;
              if (st_q.armed == RK_ACK) begin
                status = ST_REPLY;
              end else begin
                st_d.armed         = RK_ACK;
                st_d.last_acked_id = '0;
                status             = ST_ACCEPTED;
              end
            end
            OP_CLOSING: begin
              st_d.close_retx      = 1'b0;
              st_d.close_session   = req_i.session_id;
              st_d.close_is_closed = 1'b1;
              st_d.armed           = RK_CLOSE;
              status               = ST_CLOSING;
            end
            OP_REJECT: begin
              st_d.armed = RK_NONE;
              status     = ST_REJECTED;
            end
            default: begin
              status = ST_BAD_OP;
            end
          endcase
        end
      end
      ACT_OPEN: begin
        st_d.open_retx = (st_q.armed == RK_OPEN);
        st_d.armed     = RK_OPEN;
      end
      ACT_CLOSE: begin
        st_d.close_retx      = 1'b0;
        st_d.close_is_closed = 1'b0;
        st_d.close_session   = st_q.last_rx_session;
        st_d.armed           = RK_CLOSE;
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  // reply fields follow the armed kind after the update
  always_comb begin
    res_o                = '0;
    res_o.status         = status;
    res_o.reply_kind     = st_d.armed;
    res_o.payload_len    = st_d.held_len;
    unique case (st_d.armed)
      RK_OPEN: begin
        res_o.reply_retx    = st_d.open_retx;
        res_o.reply_session = OPEN_SESSION;
      end
      RK_ACK: begin
        res_o.reply_session = st_d.ack_session;
        res_o.reply_id      = st_d.ack_id_word;
      end
      RK_CLOSE: begin
        res_o.reply_retx     = st_d.close_retx;
        res_o.reply_close_op = st_d.close_is_closed;
        res_o.reply_session  = st_d.close_session;
      end
      RK_RETX: begin
        res_o.reply_session = st_d.retx_session;
        res_o.reply_id      = WORD_BITS'(st_d.retx_wanted_id);
      end
      default: begin
        res_o.reply_session = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule
